// ===== rtl/mer_pkg.sv =====
// Shared types and fixed widths for the midpoint ellipse rasterizer.
package mer_pkg;

	localparam int COORD_W  = 10;
	localparam int RADIUS_W = 9;
	localparam int COLOR_W  = 24;
	localparam int POINT_W  = 12;

	localparam int STEPX_W = RADIUS_W + 1;
	localparam int STEPY_W = RADIUS_W + 2;
	localparam int SQ_W    = 2 * RADIUS_W;
	localparam int INC_W   = SQ_W + STEPX_W + 3;
	localparam int MULA_W  = SQ_W;
	localparam int MULB_W  = 2 * (STEPX_W + 1);
	localparam int PROD_W  = MULA_W + MULB_W;
	localparam int DEC_W   = 4 * RADIUS_W + 8;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	typedef struct packed {
		logic                command;
		logic [COORD_W-1:0]  center_x;
		logic [COORD_W-1:0]  center_y;
		logic [RADIUS_W-1:0] radius_x;
		logic [RADIUS_W-1:0] radius_y;
		logic [COLOR_W-1:0]  draw_color;
	} mer_cmd_t;

	typedef struct packed {
		logic signed [POINT_W-1:0] point_x;
		logic signed [POINT_W-1:0] point_y;
		logic [COLOR_W-1:0]        pixel_color;
		logic                      last;
	} mer_pixel_t;

endpackage

// ===== rtl/midpoint_ellipse_rasterizer_core.sv =====
// Midpoint ellipse rasterizer: command decode, region update, shared multiplier and pixel port.

// A start beat latches center, radii and color and runs the multiplier setup program;
// it emits nothing. Each step beat then runs one iteration of the two-region
// midpoint algorithm and emits four mirrored pixel beats, (+x,+y), (-x,-y), (-x,+y),
// (+x,-y), one per cycle unless pixel_stall holds them, the fourth beat of the final
// iteration flagged with last. A step runs accept, update, then the four pixel beats; the
// step that leaves region one first lets the single shared 18x22 multiplier rebuild the
// decision term. A step while no ellipse is active is taken and dropped. cmd_stall is high
// after an accept until the last pixel beat of that command is taken, or until a start's setup ends.
// The decision term is held exactly as four times the real-valued midpoint decision.
module midpoint_ellipse_rasterizer_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_stall,
	input  mer_pkg::mer_cmd_t     cmd_data,
	output logic                  pixel_valid,
	input  logic                  pixel_stall,
	output mer_pkg::mer_pixel_t   pixel_data
);
	import mer_pkg::*;

	// sequencer states
	localparam logic [1:0] ST_IN  = 2'd0;
	localparam logic [1:0] ST_MUL = 2'd1;
	localparam logic [1:0] ST_UPD = 2'd2;
	localparam logic [1:0] ST_OUT = 2'd3;

	// drawing phase
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_R1   = 2'd1;
	localparam logic [1:0] PH_R2   = 2'd2;

	// multiplier program: start setup, then region-two setup
	localparam logic [3:0] OP_RX2   = 4'd0;
	localparam logic [3:0] OP_RY2   = 4'd1;
	localparam logic [3:0] OP_RX2RY = 4'd2;
	localparam logic [3:0] OP_INIT  = 4'd3;
	localparam logic [3:0] OP_TT    = 4'd4;
	localparam logic [3:0] OP_RY2TT = 4'd5;
	localparam logic [3:0] OP_UU    = 4'd6;
	localparam logic [3:0] OP_RX2UU = 4'd7;
	localparam logic [3:0] OP_RXRY  = 4'd8;
	localparam logic [3:0] OP_SWEND = 4'd9;

	// pixel beat order
	localparam logic [1:0] BT_PP = 2'd0;
	localparam logic [1:0] BT_NN = 2'd1;
	localparam logic [1:0] BT_NP = 2'd2;
	localparam logic [1:0] BT_PN = 2'd3;

	logic [1:0]                 state_q;
	logic [1:0]                 phase_q;
	logic [3:0]                 op_q;
	logic [1:0]                 beat_q;
	logic                       last_q;

	logic [COORD_W-1:0]         cx_q;
	logic [COORD_W-1:0]         cy_q;
	logic [RADIUS_W-1:0]        rx_q;
	logic [RADIUS_W-1:0]        ry_q;
	logic [COLOR_W-1:0]         color_q;
	logic [SQ_W-1:0]            rx2_q;
	logic [SQ_W-1:0]            ry2_q;

	logic [STEPX_W-1:0]         step_x_q;
	logic signed [STEPY_W-1:0]  step_y_q;
	logic [STEPX_W-1:0]         pt_x_q;
	logic signed [STEPY_W-1:0]  pt_y_q;
	logic signed [INC_W-1:0]    px_q;   // 2 ry^2 x
	logic signed [INC_W-1:0]    py_q;   // 2 rx^2 y
	logic signed [DEC_W-1:0]    dec_q;  // 4 p
	logic [PROD_W-1:0]          prod_q;

	logic cmd_fire;
	logic pix_fire;
	assign cmd_fire  = cmd_valid && !cmd_stall;
	assign pix_fire  = pixel_valid && !pixel_stall;
	assign cmd_stall = (state_q != ST_IN);

	// ---------------------------------------------------------------
	// Shared multiplier: operands picked by the program counter
	// ---------------------------------------------------------------
	logic [MULA_W-1:0]         mul_a;
	logic [MULB_W-1:0]         mul_b;
	logic [PROD_W-1:0]         prod_d;
	logic [STEPX_W:0]          t_val;
	logic signed [STEPY_W-1:0] u_val;
	logic [STEPY_W-1:0]        u_abs;

	assign t_val  = {step_x_q, 1'b1};
	assign u_val  = step_y_q - STEPY_W'(1);
	assign u_abs  = u_val[STEPY_W-1] ? STEPY_W'(-u_val) : STEPY_W'(u_val);
	assign prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (op_q)
			OP_RX2: begin
				mul_a = MULA_W'(rx_q);
				mul_b = MULB_W'(rx_q);
			end
			OP_RY2: begin
				mul_a = MULA_W'(ry_q);
				mul_b = MULB_W'(ry_q);
			end
			OP_RX2RY: begin
				mul_a = rx2_q;
				mul_b = MULB_W'(ry_q);
			end
			OP_TT: begin
				mul_a = MULA_W'(t_val);
				mul_b = MULB_W'(t_val);
			end
			OP_RY2TT: begin
				mul_a = ry2_q;
				mul_b = prod_q[MULB_W-1:0];
			end
			OP_UU: begin
				mul_a = MULA_W'(u_abs);
				mul_b = MULB_W'(u_abs);
			end
			OP_RX2UU: begin
				mul_a = rx2_q;
				mul_b = MULB_W'(prod_q[SQ_W-1:0]);
			end
			OP_RXRY: begin
				mul_a = rx2_q;
				mul_b = MULB_W'(ry2_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	logic signed [DEC_W-1:0] prod_x4;
	assign prod_x4 = signed'({{(DEC_W-PROD_W-2){1'b0}}, prod_q, 2'b00});

	// ---------------------------------------------------------------
	// One midpoint iteration
	// ---------------------------------------------------------------
	logic signed [INC_W-1:0]   rx2_e;
	logic signed [INC_W-1:0]   ry2_e;
	logic signed [INC_W-1:0]   px_inc;
	logic signed [INC_W-1:0]   py_inc;
	logic [STEPX_W-1:0]        nx_x;
	logic signed [STEPY_W-1:0] nx_y;
	logic signed [INC_W-1:0]   nx_px;
	logic signed [INC_W-1:0]   nx_py;
	logic signed [INC_W-1:0]   dinc;
	logic signed [DEC_W-1:0]   nx_dec;
	logic                      leave_r1;
	logic                      done;

	assign rx2_e  = signed'({{(INC_W-SQ_W){1'b0}}, rx2_q});
	assign ry2_e  = signed'({{(INC_W-SQ_W){1'b0}}, ry2_q});
	assign px_inc = px_q + signed'({{(INC_W-SQ_W-1){1'b0}}, ry2_q, 1'b0});
	assign py_inc = py_q - signed'({{(INC_W-SQ_W-1){1'b0}}, rx2_q, 1'b0});

	always_comb begin
		nx_x     = step_x_q;
		nx_y     = step_y_q;
		nx_px    = px_q;
		nx_py    = py_q;
		dinc     = '0;
		leave_r1 = 1'b0;
		if (phase_q == PH_R1) begin
			nx_x  = step_x_q + STEPX_W'(1);
			nx_px = px_inc;
			if (dec_q[DEC_W-1]) begin
				dinc = px_inc + ry2_e;
			end else begin
				nx_y  = step_y_q - STEPY_W'(1);
				nx_py = py_inc;
				dinc  = px_inc - py_inc + ry2_e;
			end
			leave_r1 = nx_y[STEPY_W-1] || (nx_px > nx_py);
		end else begin
			nx_y  = step_y_q - STEPY_W'(1);
			nx_py = py_inc;
			if (dec_q[DEC_W-1] || (dec_q == '0)) begin
				nx_x  = step_x_q + STEPX_W'(1);
				nx_px = px_inc;
				dinc  = px_inc - py_inc + rx2_e;
			end else begin
				dinc = rx2_e - py_inc;
			end
		end
		nx_dec = dec_q + signed'({{(DEC_W-INC_W-2){dinc[INC_W-1]}}, dinc, 2'b00});
		done   = ((phase_q == PH_R2) || leave_r1) && nx_y[STEPY_W-1];
	end

	// ---------------------------------------------------------------
	// Control
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IN;
			phase_q <= PH_IDLE;
			op_q    <= OP_RX2;
			beat_q  <= BT_PP;
			last_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IN: begin
					if (cmd_fire) begin
						if (cmd_data.command == CMD_START) begin
							// abort anything in flight, set up the new shape
							phase_q <= PH_R1;
							op_q    <= OP_RX2;
							state_q <= ST_MUL;
						end else if (phase_q == PH_R1 || phase_q == PH_R2) begin
							state_q <= ST_UPD;
						end
					end
				end
				ST_UPD: begin
					last_q <= done;
					beat_q <= BT_PP;
					if (done) begin
						phase_q <= PH_IDLE;
					end else if (leave_r1) begin
						phase_q <= PH_R2;
					end
					if (leave_r1) begin
						op_q    <= OP_TT;
						state_q <= ST_MUL;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_MUL: begin
					if (op_q == OP_INIT) begin
						state_q <= ST_IN;
					end else if (op_q == OP_SWEND) begin
						beat_q  <= BT_PP;
						state_q <= ST_OUT;
					end else begin
						op_q <= op_q + 4'd1;
					end
				end
				ST_OUT: begin
					if (pix_fire) begin
						beat_q <= beat_q + 2'd1;
						if (beat_q == BT_PN) begin
							state_q <= ST_IN;
						end
					end
				end
				default: begin
					state_q <= ST_IN;
				end
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Datapath registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (state_q == ST_IN && cmd_fire) begin
			if (cmd_data.command == CMD_START) begin
				cx_q     <= cmd_data.center_x;
				cy_q     <= cmd_data.center_y;
				rx_q     <= cmd_data.radius_x;
				ry_q     <= cmd_data.radius_y;
				color_q  <= cmd_data.draw_color;
				step_x_q <= '0;
				step_y_q <= signed'(STEPY_W'(cmd_data.radius_y));
			end else begin
				// snapshot the offset that this step plots
				pt_x_q <= step_x_q;
				pt_y_q <= step_y_q;
			end
		end
		if (state_q == ST_UPD) begin
			step_x_q <= nx_x;
			step_y_q <= nx_y;
			px_q     <= nx_px;
			py_q     <= nx_py;
			dec_q    <= nx_dec;
		end
		if (state_q == ST_MUL) begin
			prod_q <= prod_d;
			case (op_q)
				OP_RY2: begin
					rx2_q <= prod_q[SQ_W-1:0];
				end
				OP_RX2RY: begin
					ry2_q <= prod_q[SQ_W-1:0];
				end
				OP_INIT: begin
					// 4 ry^2 - 4 rx^2 ry + rx^2
					dec_q <= signed'({{(DEC_W-SQ_W-2){1'b0}}, ry2_q, 2'b00}) - prod_x4
						+ signed'({{(DEC_W-SQ_W){1'b0}}, rx2_q});
					px_q  <= '0;
					py_q  <= signed'({prod_q[INC_W-2:0], 1'b0});
				end
				OP_UU: begin
					// ry^2 (2x+1)^2
					dec_q <= signed'({{(DEC_W-PROD_W){1'b0}}, prod_q});
				end
				OP_RXRY: begin
					// + 4 rx^2 (y-1)^2
					dec_q <= dec_q + prod_x4;
				end
				OP_SWEND: begin
					// - 4 rx^2 ry^2
					dec_q <= dec_q - prod_x4;
				end
				default: begin
				end
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Pixel port: four mirrored beats from held registers
	// ---------------------------------------------------------------
	logic                      neg_x;
	logic                      neg_y;
	logic signed [POINT_W-1:0] dx;
	logic signed [POINT_W-1:0] dy;

	always_comb begin
		case (beat_q)
			BT_PP: begin
				neg_x = 1'b0;
				neg_y = 1'b0;
			end
			BT_NN: begin
				neg_x = 1'b1;
				neg_y = 1'b1;
			end
			BT_NP: begin
				neg_x = 1'b1;
				neg_y = 1'b0;
			end
			BT_PN: begin
				neg_x = 1'b0;
				neg_y = 1'b1;
			end
			default: begin
				neg_x = 1'b0;
				neg_y = 1'b0;
			end
		endcase
	end

	assign dx = signed'({{(POINT_W-STEPX_W){1'b0}}, pt_x_q});
	assign dy = signed'({{(POINT_W-STEPY_W){pt_y_q[STEPY_W-1]}}, pt_y_q});

	assign pixel_valid             = (state_q == ST_OUT);
	assign pixel_data.point_x      = signed'({{(POINT_W-COORD_W){1'b0}}, cx_q})
		+ (neg_x ? -dx : dx);
	assign pixel_data.point_y      = signed'({{(POINT_W-COORD_W){1'b0}}, cy_q})
		+ (neg_y ? -dy : dy);
	assign pixel_data.pixel_color  = color_q;
	assign pixel_data.last         = last_q && (beat_q == BT_PN);

endmodule
